// ===== sv/rpn_pkg.sv =====
package rpn_pkg;

    // field widths of the request and response words
    localparam int REQ_W = 4;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;
    localparam int DEP_W = 5;

    // divider operand widths
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PEEK = 4'd1;
    localparam logic [REQ_W-1:0] REQ_ADD  = 4'd2;
    localparam logic [REQ_W-1:0] REQ_SUB  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_MUL  = 4'd4;
    localparam logic [REQ_W-1:0] REQ_DIV  = 4'd5;
    localparam logic [REQ_W-1:0] REQ_SWAP = 4'd6;
    localparam logic [REQ_W-1:0] REQ_SUM  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_MEAN = 4'd8;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [ST_W-1:0] ST_ONE   = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV0  = 3'd4;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    // divider launch and result
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    // magnitude of a 32-bit signed value
    function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
        mag32 = v[VAL_W-1] ? (~v + 32'd1) : v;
    endfunction

    // apply a sign to a magnitude and saturate to 32 bits
    function automatic logic [VAL_W-1:0] signed_sat(input logic [63:0] mag, input logic neg);
        if (neg) begin
            if (mag >= 64'h8000_0000) signed_sat = VAL_MIN;
            else                      signed_sat = ~mag[VAL_W-1:0] + 32'd1;
        end else begin
            if (mag > 64'h7fff_ffff)  signed_sat = VAL_MAX;
            else                      signed_sat = mag[VAL_W-1:0];
        end
    endfunction

endpackage

// ===== sv/rpn_req_if.sv =====
interface rpn_req_if import rpn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] operand_value;

    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

// ===== sv/rpn_rsp_if.sv =====
interface rpn_rsp_if import rpn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] top_value;
    logic                    top_valid;
    logic [DEP_W-1:0]        stack_depth;

    modport source (output valid, output status, output top_value, output top_valid,
                    output stack_depth, input ready);
    modport sink   (input valid, input status, input top_value, input top_valid,
                    input stack_depth, output ready);
endinterface

// ===== sv/rpn_div.sv =====
module rpn_div import rpn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_NW-1:0] r_q, n_q;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_den, n_den;
    logic [DIV_DW:0]   shifted;
    logic              ge;

    // one quotient bit per cycle, restoring; hold the divisor from the start word
    always_comb begin
        shifted = {r_rem, r_q[DIV_NW-1]};
        ge      = shifted >= {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_NW - 1);
            n_q    = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = ge ? DIV_DW'(shifted - {1'b0, r_den}) : shifted[DIV_DW-1:0];
            n_q   = {r_q[DIV_NW-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

// ===== sv/rpn_stack_calculator.sv =====
// Channel  Dir  Fields                                          Accepted when
// i_req    in   req_type, operand_value                         valid && ready
// o_rsp    out  status, top_value, top_valid, stack_depth       valid && ready
//
// Push, peek, error cases and unknown codes finish straight from idle; add, sub,
// swap, mul and divide read the second entry first. Sum walks the stack memory's
// single read port over all entries; divide and mean use the one-bit-per-cycle
// divider over a 64-bit dividend.
// Synchronous active-low reset empties the stack; the entry memory is not cleared.
// A new request is taken only while no request is in work; a finished response
// waits in the output register, which holds the sequencer when still occupied.
module rpn_stack_calculator import rpn_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rpn_req_if.sink      i_req,
    rpn_rsp_if.source    o_rsp
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = 33 + $clog2(STACK_DEPTH);
    localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;
    localparam logic signed [SW-1:0] SUM_MAX = {{(SW-32){1'b0}}, VAL_MAX};
    localparam logic signed [SW-1:0] SUM_MIN = {{(SW-32){1'b1}}, VAL_MIN};

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RDQ    = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_SUM    = 8'b0001_0000,
        S_SUMFIN = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    // stack memory: entries below the top, the top itself lives in r_top
    logic [VAL_W-1:0] mem [STACK_DEPTH];
    logic [VAL_W-1:0] r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_wa, rd_addr;
    logic [VAL_W-1:0] mem_wd;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [VAL_W-1:0]     r_top, n_top;
    logic [REQ_W-1:0]     r_op, n_op;
    logic [ST_W-1:0]      r_st, n_st;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic signed [SW-1:0] r_acc, n_acc;
    logic signed [63:0]   r_prod, n_prod;
    logic                 r_neg, n_neg;

    logic                 r_ovalid, n_ovalid;
    logic [ST_W-1:0]      r_ost, n_ost;
    logic [VAL_W-1:0]     r_otop, n_otop;
    logic                 r_otv, n_otv;
    logic [DEP_W-1:0]     r_odep, n_odep;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic              accept;
    logic [32:0]       add_s, sub_s;
    logic [63:0]       prod_mag, prod_rnd;
    logic [SW-1:0]     acc_mag;
    logic [VAL_W-1:0]  q_mag, p_mag;
    logic [31:0]       cnt32;

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // datapath terms
    always_comb begin
        add_s    = {r_rdata[31], r_rdata} + {r_top[31], r_top};
        sub_s    = {r_rdata[31], r_rdata} - {r_top[31], r_top};
        prod_mag = r_prod[63] ? (~r_prod + 64'd1) : r_prod;
        prod_rnd = (prod_mag + HALF) >> FRAC_BITS;
        acc_mag  = r_acc[SW-1] ? (~r_acc + SW'(1)) : r_acc;
        q_mag    = mag32(r_rdata);
        p_mag    = mag32(r_top);
        cnt32    = 32'(r_cnt);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_top    = r_top;
        n_op     = r_op;
        n_st     = r_st;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_neg    = r_neg;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_ost    = r_ost;
        n_otop   = r_otop;
        n_otv    = r_otv;
        n_odep   = r_odep;
        mem_we   = 1'b0;
        mem_wa   = AW'(r_cnt - CW'(1));
        mem_wd   = r_top;
        rd_addr  = '0;
        div_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_req.req_type;
                    n_st    = ST_OK;
                    n_state = S_DONE;
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            if (32'(r_cnt) >= STACK_DEPTH) begin
                                n_st = ST_FULL;
                            end else begin
                                // spill the old top into memory
                                mem_we = (r_cnt != '0);
                                n_top  = i_req.operand_value;
                                n_cnt  = r_cnt + CW'(1);
                            end
                        end
                        REQ_PEEK: begin
                            if (r_cnt == '0) n_st = ST_EMPTY;
                        end
                        REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_SWAP: begin
                            if (r_cnt == '0)            n_st = ST_EMPTY;
                            else if (r_cnt == CW'(1))   n_st = ST_ONE;
                            else                        n_state = S_RDQ;
                        end
                        REQ_SUM, REQ_MEAN: begin
                            if (r_cnt == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_acc   = SW'(signed'(r_top));
                                n_idx   = '0;
                                n_pend  = 1'b0;
                                n_state = S_SUM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDQ: begin
                rd_addr = AW'(r_cnt - CW'(2));
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    REQ_ADD: begin
                        n_top = (add_s[32] != add_s[31]) ? (add_s[32] ? VAL_MIN : VAL_MAX)
                                                         : add_s[31:0];
                        n_cnt = r_cnt - CW'(1);
                    end
                    REQ_SUB: begin
                        n_top = (sub_s[32] != sub_s[31]) ? (sub_s[32] ? VAL_MIN : VAL_MAX)
                                                         : sub_s[31:0];
                        n_cnt = r_cnt - CW'(1);
                    end
                    REQ_MUL: begin
                        n_prod  = 64'(signed'(r_rdata)) * 64'(signed'(r_top));
                        n_state = S_MUL;
                    end
                    REQ_DIV: begin
                        if (r_top == '0) begin
                            n_st  = ST_DIV0;
                            n_top = r_rdata[31] ? VAL_MIN : ((r_rdata == '0) ? '0 : VAL_MAX);
                            n_cnt = r_cnt - CW'(1);
                        end else begin
                            div_req.start = 1'b1;
                            div_req.num   = (64'(q_mag) << FRAC_BITS) + 64'(p_mag >> 1);
                            div_req.den   = p_mag;
                            n_neg         = r_rdata[31] ^ r_top[31];
                            n_state       = S_DIV;
                        end
                    end
                    default: begin
                        // swap: old top goes below, second entry becomes top
                        mem_we = 1'b1;
                        mem_wa = AW'(r_cnt - CW'(2));
                        mem_wd = r_top;
                        n_top  = r_rdata;
                    end
                endcase
            end
            S_MUL: begin
                n_top   = signed_sat(prod_rnd, r_prod[63]);
                n_cnt   = r_cnt - CW'(1);
                n_state = S_DONE;
            end
            S_SUM: begin
                // add last cycle's read, issue the next one
                if (r_pend) n_acc = r_acc + SW'(signed'(r_rdata));
                if (r_idx != r_cnt - CW'(1)) begin
                    rd_addr = AW'(r_idx);
                    n_idx   = r_idx + CW'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) n_state = S_SUMFIN;
                end
            end
            S_SUMFIN: begin
                if (r_op == REQ_SUM) begin
                    n_top   = (r_acc > SUM_MAX) ? VAL_MAX :
                              ((r_acc < SUM_MIN) ? VAL_MIN : VAL_W'(r_acc));
                    n_cnt   = CW'(1);
                    n_state = S_DONE;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = 64'(acc_mag) + 64'(r_cnt >> 1);
                    div_req.den   = DIV_DW'(r_cnt);
                    n_neg         = r_acc[SW-1];
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_top   = signed_sat(div_rsp.quo, r_neg);
                    n_cnt   = (r_op == REQ_DIV) ? r_cnt - CW'(1) : CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_st;
                    n_otop   = (r_cnt != '0) ? r_top : '0;
                    n_otv    = (r_cnt != '0);
                    n_odep   = cnt32[DEP_W-1:0];
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_top  <= n_top;
        r_op   <= n_op;
        r_st   <= n_st;
        r_idx  <= n_idx;
        r_pend <= n_pend;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_ost  <= n_ost;
        r_otop <= n_otop;
        r_otv  <= n_otv;
        r_odep <= n_odep;
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ost;
    assign o_rsp.top_value   = r_otop;
    assign o_rsp.top_valid   = r_otv;
    assign o_rsp.stack_depth = r_odep;

    // the entry count never passes the stack size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= STACK_DEPTH)
        else $error("entry count beyond stack size");

    // a push onto a stack with room grows it by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_PUSH && 32'(r_cnt) < STACK_DEPTH)
        |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("push did not grow the stack");

    // divider results arrive only while the sequencer waits for them
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider result outside divide wait");

    // a response is loaded only from the done state
    a_rsp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !$past(r_ovalid)) |-> $past(r_state) == S_DONE)
        else $error("response loaded outside done state");

endmodule
